### design/cbod_pkg.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbod_pkg - shared types and constants for the cpu bus / oam dma block
// bus operation and route codes, address map constants, stream widths
// ---------------------------------------------------------------------------
package cbod_pkg;

  // work ram size (power of two) and its index width
  localparam int RAM_BYTES = 2048;
  localparam int RAM_AW    = $clog2(RAM_BYTES);

  // stream widths
  localparam int IN_TDATA_W  = 72;
  localparam int OUT_TDATA_W = 64;
  localparam int OP_W        = 2;
  localparam int ROUTE_W     = 3;

  // address map
  localparam logic [15:0] RAM_TOP      = 16'h1FFF;
  localparam logic [15:0] PPU_TOP      = 16'h3FFF;
  localparam logic [15:0] PPU_REG_MASK = 16'h0007;
  localparam logic [15:0] OAM_DMA_REG  = 16'h4014;
  localparam logic [15:0] APU_STATUS   = 16'h4015;
  localparam logic [15:0] PAD_PORT_ONE = 16'h4016;
  localparam logic [15:0] PAD_PORT_TWO = 16'h4017;

  typedef enum logic [OP_W-1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_DMA   = 2'd2
  } op_t;

  typedef enum logic [ROUTE_W-1:0] {
    RT_NONE   = 3'd0,
    RT_MAPPER = 3'd1,
    RT_RAM    = 3'd2,
    RT_PPU    = 3'd3,
    RT_APU    = 3'd4,
    RT_PAD    = 3'd5
  } route_t;

endpackage
`default_nettype wire

### design/console_cpu_bus_with_oam_dma_core.sv
`default_nettype none
// ---------------------------------------------------------------------------
// console_cpu_bus_with_oam_dma_core - cpu bus decoder with oam dma engine
// routes cpu reads, writes and dma ticks to mapper, work ram, ppu, apu and
// the two controller ports; runs the 256-byte sprite dma
// ---------------------------------------------------------------------------
//
//  channel | direction | tdata                          | tuser
//  --------+-----------+--------------------------------+----------------
//  in_     | slave     | bus access and device inputs   | operation
//  out_    | master    | read byte, device strobes, dma | route
//
// one item per clock sustained while the result register is not stalled; each
// item passes through the input stage (work ram read is issued at accept) and
// then the result register, which drives out_tvalid until out_tready takes it.
// synchronous active-low reset clears the stages, controller shifters and
// dma state; the work ram is not cleared.
// a stalled result register stops the input stage; in_tready then drops.
// ---------------------------------------------------------------------------
module console_cpu_bus_with_oam_dma_core (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_tvalid,
  output logic                               in_tready,
  // [15:0] address, [23:16] write_data, [24] peek_only, [25] cart_claims,
  // [33:26] cart_read_data, [41:34] ppu_read_data, [49:42] apu_status_data,
  // [50] cycle_odd, [58:51] pad_one_buttons, [66:59] pad_two_buttons
  input  logic [cbod_pkg::IN_TDATA_W-1:0]    in_tdata,
  // [1:0] operation
  input  logic [cbod_pkg::OP_W-1:0]          in_tuser,
  output logic                               out_tvalid,
  input  logic                               out_tready,
  // [7:0] read_result, [23:8] device_address, [31:24] device_data,
  // [32] device_write, [33] device_read, [34] device_peek, [35] oam_write,
  // [43:36] oam_byte, [44] dma_busy, [60:45] dma_source
  output logic [cbod_pkg::OUT_TDATA_W-1:0]   out_tdata,
  // [2:0] route
  output logic [cbod_pkg::ROUTE_W-1:0]       out_tuser
);
  import cbod_pkg::*;

  // handshake and stage control
  logic s1_valid_r;
  logic out_valid_r;
  logic s1_adv;
  logic s1_commit;
  logic accept;

  // input stage payload
  op_t                   s1_op_r;
  logic [IN_TDATA_W-1:0] s1_data_r;

  // write-to-read bypass for the ram read issued in the same cycle as a write
  logic       byp_hit_r;
  logic [7:0] byp_data_r;

  // architectural state
  logic [7:0] pad0_r, pad0_nxt;
  logic [7:0] pad1_r, pad1_nxt;
  logic [7:0] dma_page_r, dma_page_nxt;
  logic [7:0] dma_offset_r, dma_offset_nxt;
  logic [7:0] dma_latch_r, dma_latch_nxt;
  logic       dma_waiting_r, dma_waiting_nxt;
  logic       dma_running_r, dma_running_nxt;

  // result register
  logic [OUT_TDATA_W-1:0] out_data_r;
  route_t                 out_route_r;

  // unpacked fields of the item in the input stage
  logic [15:0] f_address;
  logic [7:0]  f_write_data;
  logic        f_peek;
  logic        f_cart_claims;
  logic [7:0]  f_cart_data;
  logic [7:0]  f_ppu_data;
  logic [7:0]  f_apu_data;
  logic        f_cycle_odd;
  logic [7:0]  f_pad_one;
  logic [7:0]  f_pad_two;

  assign f_address     = s1_data_r[15:0];
  assign f_write_data  = s1_data_r[23:16];
  assign f_peek        = s1_data_r[24];
  assign f_cart_claims = s1_data_r[25];
  assign f_cart_data   = s1_data_r[33:26];
  assign f_ppu_data    = s1_data_r[41:34];
  assign f_apu_data    = s1_data_r[49:42];
  assign f_cycle_odd   = s1_data_r[50];
  assign f_pad_one     = s1_data_r[58:51];
  assign f_pad_two     = s1_data_r[66:59];

  // ram interface
  logic              ram_we;
  logic              ram_we_raw;
  logic [RAM_AW-1:0] ram_waddr;
  logic [RAM_AW-1:0] ram_raddr;
  logic [7:0]        ram_rdata;
  logic [7:0]        ram_byte;

  // result fields
  logic [7:0]  read_result;
  route_t      route;
  logic [15:0] dev_addr;
  logic [7:0]  dev_data;
  logic        dev_write;
  logic        dev_read;
  logic        dev_peek;
  logic        oam_write;
  logic [7:0]  oam_byte;

  // decode helpers
  logic        fetch_en;
  logic        store_en;
  logic        dma_rd;
  logic [15:0] fetch_addr;
  logic        fetch_peek;
  logic [7:0]  fetch_val;
  logic [15:0] dma_src_eff;

  // handshake: the input stage moves on when the result register is free
  assign s1_adv     = !out_valid_r || out_tready;
  assign s1_commit  = s1_valid_r && s1_adv;
  assign in_tready  = !s1_valid_r || s1_adv;
  assign accept     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;
  assign out_tuser  = out_route_r;

  // ram byte for the item in the input stage, with same-cycle write bypass
  assign ram_byte = byp_hit_r ? byp_data_r : ram_rdata;

  // operation sequencing and dma state
  always_comb begin
    fetch_en        = 1'b0;
    store_en        = 1'b0;
    dma_rd          = 1'b0;
    fetch_addr      = f_address;
    fetch_peek      = 1'b0;
    oam_write       = 1'b0;
    oam_byte        = 8'd0;
    dma_offset_nxt  = dma_offset_r;
    dma_waiting_nxt = dma_waiting_r;
    dma_running_nxt = dma_running_r;
    unique case (s1_op_r)
      OP_READ: begin
        fetch_en   = 1'b1;
        fetch_peek = f_peek;
      end
      OP_WRITE: begin
        store_en = 1'b1;
      end
      OP_DMA: begin
        if (dma_running_r) begin
          if (dma_waiting_r) begin
            // alignment dummy until an odd cycle
            if (f_cycle_odd) begin
              dma_waiting_nxt = 1'b0;
            end
          end else if (!f_cycle_odd) begin
            fetch_en   = 1'b1;
            dma_rd     = 1'b1;
            fetch_addr = {dma_page_r, dma_offset_r};
          end else begin
            oam_write      = 1'b1;
            oam_byte       = dma_latch_r;
            dma_offset_nxt = dma_offset_r + 8'd1;
            // last byte of the page ends the transfer
            if (dma_offset_r == 8'hFF) begin
              dma_running_nxt = 1'b0;
              dma_waiting_nxt = 1'b1;
            end
          end
        end
      end
      default: begin
      end
    endcase
  end

  // address decode for reads and writes
  always_comb begin
    route       = RT_NONE;
    dev_addr    = 16'd0;
    dev_data    = 8'd0;
    dev_write   = 1'b0;
    dev_read    = 1'b0;
    dev_peek    = 1'b0;
    fetch_val   = 8'd0;
    ram_we_raw  = 1'b0;
    ram_waddr   = fetch_addr[RAM_AW-1:0];
    pad0_nxt    = pad0_r;
    pad1_nxt    = pad1_r;
    dma_page_nxt = dma_page_r;
    if (fetch_en) begin
      if (f_cart_claims) begin
        route     = RT_MAPPER;
        dev_addr  = fetch_addr;
        dev_read  = 1'b1;
        fetch_val = f_cart_data;
      end else if (fetch_addr <= RAM_TOP) begin
        route     = RT_RAM;
        dev_addr  = {{(16-RAM_AW){1'b0}}, fetch_addr[RAM_AW-1:0]};
        dev_read  = 1'b1;
        fetch_val = ram_byte;
      end else if (fetch_addr <= PPU_TOP) begin
        route     = RT_PPU;
        dev_addr  = fetch_addr & PPU_REG_MASK;
        dev_read  = 1'b1;
        dev_peek  = fetch_peek;
        fetch_val = f_ppu_data;
      end else if (fetch_addr == APU_STATUS) begin
        route     = RT_APU;
        dev_addr  = fetch_addr;
        dev_read  = 1'b1;
        fetch_val = f_apu_data;
      end else if (fetch_addr == PAD_PORT_ONE || fetch_addr == PAD_PORT_TWO) begin
        // serial controller read: msb out, shift left with zero fill
        route    = RT_PAD;
        dev_addr = fetch_addr;
        dev_read = 1'b1;
        if (fetch_addr[0]) begin
          fetch_val = {7'd0, pad1_r[7]};
          pad1_nxt  = {pad1_r[6:0], 1'b0};
        end else begin
          fetch_val = {7'd0, pad0_r[7]};
          pad0_nxt  = {pad0_r[6:0], 1'b0};
        end
      end
    end else if (store_en) begin
      if (f_cart_claims) begin
        route     = RT_MAPPER;
        dev_addr  = f_address;
        dev_data  = f_write_data;
        dev_write = 1'b1;
      end else if (f_address <= RAM_TOP) begin
        route      = RT_RAM;
        dev_addr   = {{(16-RAM_AW){1'b0}}, f_address[RAM_AW-1:0]};
        dev_data   = f_write_data;
        dev_write  = 1'b1;
        ram_we_raw = 1'b1;
        ram_waddr  = f_address[RAM_AW-1:0];
      end else if (f_address <= PPU_TOP) begin
        route     = RT_PPU;
        dev_addr  = f_address & PPU_REG_MASK;
        dev_data  = f_write_data;
        dev_write = 1'b1;
      end else if (f_address == OAM_DMA_REG) begin
        // dma start handled with the dma state below
        dma_page_nxt = f_write_data;
      end else if (f_address <= APU_STATUS || f_address == PAD_PORT_TWO) begin
        route     = RT_APU;
        dev_addr  = f_address;
        dev_data  = f_write_data;
        dev_write = 1'b1;
      end else if (f_address == PAD_PORT_ONE) begin
        // strobe latches both controllers
        route     = RT_PAD;
        dev_addr  = f_address;
        dev_data  = f_write_data;
        dev_write = 1'b1;
        pad0_nxt  = f_pad_one;
        pad1_nxt  = f_pad_two;
      end
    end
  end

  // dma start overrides offset and running; waiting is left alone
  logic       dma_start;
  logic [7:0] offset_fin;
  logic       running_fin;

  always_comb begin
    dma_start     = store_en && !f_cart_claims && (f_address == OAM_DMA_REG);
    offset_fin    = dma_start ? 8'd0 : dma_offset_nxt;
    running_fin   = dma_start ? 1'b1 : dma_running_nxt;
    read_result   = (s1_op_r == OP_READ) ? fetch_val : 8'd0;
    dma_latch_nxt = dma_rd ? fetch_val : dma_latch_r;
    // source address seen by the item accepted in this cycle
    dma_src_eff   = s1_commit ? {dma_page_nxt, offset_fin} : {dma_page_r, dma_offset_r};
  end

  // ram ports: write commits with the item, read issued at accept
  assign ram_we    = s1_commit && ram_we_raw;
  assign ram_raddr = (op_t'(in_tuser) == OP_DMA) ? dma_src_eff[RAM_AW-1:0]
                                                 : in_tdata[RAM_AW-1:0];

  cbod_ram #(
    .WIDTH(8),
    .DEPTH(RAM_BYTES)
  ) u_ram (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(f_write_data),
    .re   (accept),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  // input stage
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (accept) begin
      s1_valid_r <= 1'b1;
    end else if (s1_adv) begin
      s1_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_op_r    <= op_t'(in_tuser);
      s1_data_r  <= in_tdata;
      byp_hit_r  <= ram_we && (ram_waddr == ram_raddr);
      byp_data_r <= f_write_data;
    end
  end

  // architectural state advances when the item commits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pad0_r        <= 8'd0;
      pad1_r        <= 8'd0;
      dma_page_r    <= 8'd0;
      dma_offset_r  <= 8'd0;
      dma_latch_r   <= 8'd0;
      dma_waiting_r <= 1'b1;
      dma_running_r <= 1'b0;
    end else if (s1_commit) begin
      pad0_r        <= pad0_nxt;
      pad1_r        <= pad1_nxt;
      dma_page_r    <= dma_page_nxt;
      dma_offset_r  <= offset_fin;
      dma_latch_r   <= dma_latch_nxt;
      dma_waiting_r <= dma_waiting_nxt;
      dma_running_r <= running_fin;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (s1_commit) begin
      out_valid_r <= 1'b1;
    end else if (out_tready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_commit) begin
      out_route_r <= route;
      out_data_r  <= {3'd0, dma_page_nxt, offset_fin, running_fin, oam_byte, oam_write,
                      dev_peek, dev_read, dev_write, dev_data, dev_addr, read_result};
    end
  end

endmodule
`default_nettype wire

### design/cbod_ram.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbod_ram - generic single write port ram
// one write and one registered read per cycle, read data holds without re
// ---------------------------------------------------------------------------
module cbod_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2048
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule
`default_nettype wire

### design/cbod_checker.sv
`default_nettype none
// ---------------------------------------------------------------------------
// cbod_checker - port-level checks for the cpu bus / oam dma block
// watches the result stream for consistent routing and strobes
// ---------------------------------------------------------------------------
module cbod_checker (
  input wire logic                             clk,
  input wire logic                             rst_n,
  input wire logic                             out_tvalid,
  input wire logic                             out_tready,
  input wire logic [cbod_pkg::OUT_TDATA_W-1:0] out_tdata,
  input wire logic [cbod_pkg::ROUTE_W-1:0]     out_tuser
);
  import cbod_pkg::*;

  // a device is either read or written, never both
  a_rd_wr_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !(out_tdata[32] && out_tdata[33]))
    else $error("device read and write strobes together");

  // route code stays within the device list
  a_route_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> (out_tuser <= RT_PAD))
    else $error("route code out of range");

  // an oam store is a dma step with no bus access
  a_oam_unrouted: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[35] |-> out_tuser == RT_NONE && out_tdata[7:0] == 8'd0)
    else $error("oam store with a bus access");

  // a nonzero read byte only comes from a routed read
  a_read_src: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[7:0] != 8'd0) |-> out_tdata[33] && out_tuser != RT_NONE)
    else $error("read byte without a device read");

  // a stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("stalled result changed");

endmodule

bind console_cpu_bus_with_oam_dma_core cbod_checker u_cbod_checker (.*);
`default_nettype wire

### sim/cbod_bus_checker.sv
// ---------------------------------------------------------------------------
// cbod_bus_checker - result checker for the cpu bus / oam dma block
// watches both stream channels, predicts each result from the accepted
// bus item and compares it field by field with what the block returns
// ---------------------------------------------------------------------------
module cbod_bus_checker (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [cbod_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  logic [cbod_pkg::OP_W-1:0]        in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [cbod_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  logic [cbod_pkg::ROUTE_W-1:0]     out_tuser,
  output int                               fault_count,
  output int                               outstanding
);
  import cbod_pkg::*;

  // one result, laid out as out_tdata[60:0] followed by the route
  typedef struct packed {
    logic [15:0] dma_src;
    logic        dma_busy;
    logic [7:0]  oam_byte;
    logic        oam_wr;
    logic        dev_peek;
    logic        dev_rd;
    logic        dev_wr;
    logic [7:0]  dev_data;
    logic [15:0] dev_addr;
    logic [7:0]  rd_byte;
    route_t      route;
  } bus_result_t;

  logic [7:0]  wram [RAM_BYTES];
  logic [7:0]  pad_sr [2];
  logic [7:0]  sprite_page;
  logic [7:0]  sprite_offset;
  logic [7:0]  sprite_latch;
  logic        align_wait;
  logic        xfer_on;
  bus_result_t bus_results_due [$];
  int          fault_total = 0;

  function automatic string fmt_result(input bus_result_t r);
    return $sformatf({"rd=%h route=%0d addr=%h data=%h wr=%b rd=%b peek=%b ",
                      "oam=%b/%h busy=%b src=%h"},
                     r.rd_byte, r.route, r.dev_addr, r.dev_data, r.dev_wr, r.dev_rd,
                     r.dev_peek, r.oam_wr, r.oam_byte, r.dma_busy, r.dma_src);
  endfunction

  task automatic note_fault(input string why, input logic has_want,
                            input bus_result_t want, input bus_result_t got);
    fault_total++;
    if (fault_total <= 10) begin
      $display("%m: %s at %0t", why, $time);
      if (has_want)
        $display("  expected %s", fmt_result(want));
      $display("  actual   %s", fmt_result(got));
    end
  endtask

  // routed read, shared by cpu reads and dma source reads
  task automatic fetch_byte(input logic [15:0] a, input logic peek,
                            input logic [IN_TDATA_W-1:0] d,
                            inout bus_result_t r, output logic [7:0] v);
    logic [RAM_AW-1:0] idx;
    idx = a[RAM_AW-1:0];
    v = 8'h00;
    if (d[25]) begin
      r.route = RT_MAPPER; r.dev_addr = a; r.dev_rd = 1'b1; v = d[33:26];
    end else if (a <= RAM_TOP) begin
      r.route = RT_RAM; r.dev_addr = 16'(idx); r.dev_rd = 1'b1; v = wram[idx];
    end else if (a <= PPU_TOP) begin
      r.route = RT_PPU; r.dev_addr = a & PPU_REG_MASK; r.dev_rd = 1'b1;
      r.dev_peek = peek; v = d[41:34];
    end else if (a == APU_STATUS) begin
      r.route = RT_APU; r.dev_addr = a; r.dev_rd = 1'b1; v = d[49:42];
    end else if (a == PAD_PORT_ONE || a == PAD_PORT_TWO) begin
      // serial pad read: msb out in bit 0, shift left with zero fill
      r.route = RT_PAD; r.dev_addr = a; r.dev_rd = 1'b1;
      v = {7'd0, pad_sr[a[0]][7]};
      pad_sr[a[0]] = pad_sr[a[0]] << 1;
    end
  endtask

  task automatic store_byte(input logic [15:0] a, input logic [7:0] wd,
                            input logic [IN_TDATA_W-1:0] d, inout bus_result_t r);
    if (d[25]) begin
      r.route = RT_MAPPER; r.dev_addr = a; r.dev_data = wd; r.dev_wr = 1'b1;
    end else if (a <= RAM_TOP) begin
      wram[a[RAM_AW-1:0]] = wd;
      r.route = RT_RAM; r.dev_addr = 16'(a[RAM_AW-1:0]); r.dev_data = wd; r.dev_wr = 1'b1;
    end else if (a <= PPU_TOP) begin
      r.route = RT_PPU; r.dev_addr = a & PPU_REG_MASK; r.dev_data = wd; r.dev_wr = 1'b1;
    end else if (a == OAM_DMA_REG) begin
      // restart keeps the alignment state as it is
      sprite_page = wd; sprite_offset = 8'h00; xfer_on = 1'b1;
    end else if (a <= APU_STATUS || a == PAD_PORT_TWO) begin
      r.route = RT_APU; r.dev_addr = a; r.dev_data = wd; r.dev_wr = 1'b1;
    end else if (a == PAD_PORT_ONE) begin
      pad_sr[0] = d[58:51];
      pad_sr[1] = d[66:59];
      r.route = RT_PAD; r.dev_addr = a; r.dev_data = wd; r.dev_wr = 1'b1;
    end
  endtask

  task automatic predict_bus_access(input logic [OP_W-1:0] op,
                                    input logic [IN_TDATA_W-1:0] d,
                                    output bus_result_t r);
    logic [7:0] v;
    r = '0;
    case (op)
      OP_READ: begin
        fetch_byte(d[15:0], d[24], d, r, v);
        r.rd_byte = v;
      end
      OP_WRITE: store_byte(d[15:0], d[23:16], d, r);
      OP_DMA: begin
        if (xfer_on) begin
          if (align_wait) begin
            if (d[50]) align_wait = 1'b0;
          end else if (!d[50]) begin
            fetch_byte({sprite_page, sprite_offset}, 1'b0, d, r, v);
            sprite_latch = v;
          end else begin
            r.oam_wr = 1'b1;
            r.oam_byte = sprite_latch;
            sprite_offset = sprite_offset + 8'd1;
            if (sprite_offset == 8'h00) begin
              xfer_on = 1'b0;
              align_wait = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    r.dma_busy = xfer_on;
    r.dma_src = {sprite_page, sprite_offset};
  endtask

  always @(posedge clk) begin : monitor
    bus_result_t want;
    bus_result_t got;
    if (!rst_n) begin
      pad_sr[0] = 8'h00;
      pad_sr[1] = 8'h00;
      sprite_page = 8'h00;
      sprite_offset = 8'h00;
      sprite_latch = 8'h00;
      align_wait = 1'b1;
      xfer_on = 1'b0;
      bus_results_due.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        predict_bus_access(in_tuser, in_tdata, want);
        bus_results_due.push_back(want);
      end
      if (out_tvalid && out_tready) begin
        got = {out_tdata[60:0], out_tuser};
        if (bus_results_due.size() == 0) begin
          note_fault("result with nothing pending", 1'b0, '0, got);
        end else begin
          want = bus_results_due.pop_front();
          if (got !== want)
            note_fault("result mismatch", 1'b1, want, got);
        end
      end
    end
    outstanding <= bus_results_due.size();
    fault_count <= fault_total;
  end

endmodule

### sim/console_cpu_bus_with_oam_dma_core_tb.sv
// ---------------------------------------------------------------------------
// console_cpu_bus_with_oam_dma_core_tb - testbench for the cpu bus decoder
// drives bus reads, writes and dma ticks with random gaps and stalls;
// a short directed pass hits the address map edges and dma corner cases,
// then random traffic runs full and partial sprite transfers, pad readouts
// and ram traffic; the checker beside the block predicts every result
// ---------------------------------------------------------------------------
module console_cpu_bus_with_oam_dma_core_tb;
  import cbod_pkg::*;

  // opcode outside the defined set, the block must ignore it
  localparam logic [OP_W-1:0] OP_UNDEFINED = 2'd3;

  localparam int unsigned ITEM_GOAL   = 1675;     // directed part plus random part
  localparam int unsigned HOLD_AT     = 150;      // item count that triggers the long sink hold
  localparam int unsigned LONG_HOLD   = 240;      // cycles of the long sink hold
  localparam int unsigned CYCLE_LIMIT = 500_000;  // watchdog

  // bus item fields in tdata order, msb first, padded to tdata width on drive
  typedef struct packed {
    logic [7:0]  pad_two;
    logic [7:0]  pad_one;
    logic        odd_cycle;
    logic [7:0]  apu_status;
    logic [7:0]  ppu_byte;
    logic [7:0]  cart_byte;
    logic        cart_claim;
    logic        peek;
    logic [7:0]  wr_byte;
    logic [15:0] addr;
  } access_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic [OP_W-1:0]        in_tuser = OP_READ;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic [ROUTE_W-1:0]     out_tuser;
  int                     fault_count;
  int                     outstanding;

  // stimulus-side view of the block, used to keep fetches off work ram
  // entries that were never written and to follow the sprite transfer
  logic                   ram_known [RAM_BYTES];
  logic [RAM_AW-1:0]      ram_seen [$];
  logic [7:0]             sh_page = 8'h00;
  logic [7:0]             sh_offset = 8'h00;
  logic                   sh_on = 1'b0;
  logic                   sh_wait = 1'b1;

  int unsigned            items_done = 0;
  int unsigned            burst_left = 0;
  int unsigned            cycles = 0;

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  console_cpu_bus_with_oam_dma_core u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser)
  );

  cbod_bus_checker u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_tvalid   (in_tvalid),
    .in_tready   (in_tready),
    .in_tdata    (in_tdata),
    .in_tuser    (in_tuser),
    .out_tvalid  (out_tvalid),
    .out_tready  (out_tready),
    .out_tdata   (out_tdata),
    .out_tuser   (out_tuser),
    .fault_count (fault_count),
    .outstanding (outstanding)
  );

  // send one item; device-side bytes are random, the rest as given.
  // called at a clock edge, returns at the edge where the item is taken
  task automatic put_access(input logic [OP_W-1:0] op, input logic [15:0] addr,
                            input logic [7:0] wr_byte, input logic peek,
                            input logic claim, input logic odd);
    access_t           acc;
    logic [95:0]       noise_bits;
    logic [15:0]       src;
    logic              was_on;
    int unsigned       gap;
    int unsigned       pick;
    noise_bits = {$urandom, $urandom, $urandom};
    acc = noise_bits[$bits(access_t)-1:0];
    acc.addr = addr;
    acc.wr_byte = wr_byte;
    acc.peek = peek;
    acc.cart_claim = claim;
    acc.odd_cycle = odd;
    was_on = sh_on;

    // follow the decode far enough to know where a fetch lands;
    // an unwritten ram entry is read through the mapper instead
    case (op)
      OP_READ: begin
        if (!acc.cart_claim && addr <= RAM_TOP && !ram_known[addr[RAM_AW-1:0]])
          acc.cart_claim = 1'b1;
      end
      OP_WRITE: begin
        if (!acc.cart_claim && addr <= RAM_TOP) begin
          if (!ram_known[addr[RAM_AW-1:0]])
            ram_seen.push_back(addr[RAM_AW-1:0]);
          ram_known[addr[RAM_AW-1:0]] = 1'b1;
        end else if (!acc.cart_claim && addr == OAM_DMA_REG) begin
          sh_page = wr_byte;
          sh_offset = 8'h00;
          sh_on = 1'b1;
        end
      end
      OP_DMA: begin
        if (sh_on) begin
          if (sh_wait) begin
            if (odd) sh_wait = 1'b0;
          end else if (!odd) begin
            src = {sh_page, sh_offset};
            if (!acc.cart_claim && src <= RAM_TOP && !ram_known[src[RAM_AW-1:0]])
              acc.cart_claim = 1'b1;
          end else begin
            sh_offset = sh_offset + 8'd1;
            if (sh_offset == 8'h00) begin
              sh_on = 1'b0;
              sh_wait = 1'b1;
            end
          end
        end
      end
      default: ;
    endcase
    // idle ticks and undefined opcodes do not count toward the goal
    if (op == OP_READ || op == OP_WRITE || (op == OP_DMA && was_on))
      items_done++;

    // sender idling: mostly none, some short gaps, a few long ones,
    // and now and then a burst with no gaps at all
    gap = 0;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      pick = $urandom_range(0, 99);
      if (pick < 4)
        burst_left = $urandom_range(30, 100);
      else if (pick < 22)
        gap = $urandom_range(1, 3);
      else if (pick < 26)
        gap = $urandom_range(8, 30);
    end
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= IN_TDATA_W'(acc);
    @(posedge clk);
    while (!in_tready) @(posedge clk);
  endtask

  // stop offering and wait until every pending result has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
  endtask

  // address mix weighted toward the decoded windows and their edges
  function automatic logic [15:0] pick_addr(input logic for_read);
    int unsigned w;
    logic [RAM_AW-1:0] idx;
    w = $urandom_range(0, 99);
    if (w < 30) begin
      // reads mostly revisit written ram, through a random mirror
      if (for_read && ram_seen.size() > 0 && w < 22) begin
        idx = ram_seen[$urandom_range(0, ram_seen.size() - 1)];
        return {3'b000, 2'($urandom_range(0, 3)), idx};
      end
      return 16'($urandom_range(0, RAM_TOP));
    end
    if (w < 45) return 16'($urandom_range(16'h2000, PPU_TOP));
    if (w < 60) return 16'($urandom_range(APU_STATUS, PAD_PORT_TWO));
    if (w < 72) return 16'($urandom_range(16'h4000, 16'h4013));
    if (w < 75) return OAM_DMA_REG;
    if (w < 82) begin
      case ($urandom_range(0, 7))
        0: return 16'h0000;
        1: return RAM_TOP;
        2: return 16'h2000;
        3: return PPU_TOP;
        4: return 16'h4000;
        5: return PAD_PORT_TWO;
        6: return 16'h4018;
        default: return 16'hFFFF;
      endcase
    end
    return 16'($urandom_range(16'h4018, 16'hFFFF));
  endfunction

  function automatic logic [7:0] pick_page();
    case ($urandom_range(0, 5))
      0, 1: return 8'($urandom_range(0, 8'h1F));      // work ram and mirrors
      2:    return 8'($urandom_range(8'h20, 8'h3F));  // ppu registers
      3:    return 8'h40;                             // apu status and pads
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic mixed_accesses(input int unsigned n);
    repeat (n) begin
      if ($urandom_range(0, 1))
        put_access(OP_READ, pick_addr(1'b1), 8'($urandom), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 99) < 12, 1'($urandom_range(0, 1)));
      else
        put_access(OP_WRITE, pick_addr(1'b0), 8'($urandom), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 99) < 12, 1'($urandom_range(0, 1)));
    end
  endtask

  // latch both pads, then clock bits out of either port
  task automatic pad_readout();
    put_access(OP_WRITE, PAD_PORT_ONE, 8'($urandom), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    repeat ($urandom_range(6, 18))
      put_access(OP_READ, $urandom_range(0, 1) ? PAD_PORT_TWO : PAD_PORT_ONE, 8'($urandom),
                 1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // start a sprite transfer and tick it with alternating cycle parity;
  // either to the end of the page or for a short random stretch
  task automatic sprite_dma(input logic [7:0] page, input logic to_end);
    int unsigned ticks;
    int unsigned n;
    logic        odd;
    odd = 1'($urandom_range(0, 1));
    put_access(OP_WRITE, OAM_DMA_REG, page, 1'b0, 1'b0, odd);
    n = $urandom_range(1, 60);
    ticks = 0;
    while (to_end ? sh_on : ticks < n) begin
      odd = ~odd;
      if ($urandom_range(0, 9) == 0)
        odd = ~odd;
      if (!to_end && $urandom_range(0, 11) == 0)
        mixed_accesses(1);
      else
        put_access(OP_DMA, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                   $urandom_range(0, 99) < 8, odd);
      ticks++;
    end
  endtask

  // fill a run of ram, then read some of it back
  task automatic ram_block();
    logic [15:0] base;
    int unsigned len;
    int unsigned k;
    base = 16'($urandom_range(0, RAM_TOP));
    len = $urandom_range(8, 40);
    for (k = 0; k < len; k++)
      put_access(OP_WRITE, 16'(base + k), 8'($urandom), 1'b0, 1'b0, 1'($urandom_range(0, 1)));
    repeat (len / 2)
      put_access(OP_READ, 16'(base + $urandom_range(0, len - 1)), 8'($urandom),
                 1'($urandom_range(0, 1)), 1'b0, 1'($urandom_range(0, 1)));
  endtask

  // anything goes, including stray dma ticks and the undefined opcode
  task automatic noise(input int unsigned n);
    logic [OP_W-1:0] op;
    repeat (n) begin
      op = ($urandom_range(0, 49) == 0) ? OP_UNDEFINED : OP_W'($urandom_range(0, 2));
      put_access(op, 16'($urandom), 8'($urandom), 1'($urandom_range(0, 1)),
                 $urandom_range(0, 99) < 30, 1'($urandom_range(0, 1)));
    end
  endtask

  // result sink: random backpressure plus one long hold while the
  // sender keeps offering, so the block fills up and drops in_tready
  initial begin : result_sink
    int unsigned pick;
    int unsigned len;
    logic        held;
    held = 1'b0;
    forever begin
      if (!held && items_done >= HOLD_AT) begin
        held = 1'b1;
        out_tready <= 1'b0;
        repeat (LONG_HOLD) @(posedge clk);
      end else begin
        pick = $urandom_range(0, 99);
        if (pick < 70) begin
          out_tready <= 1'b1;
          len = (pick < 10) ? $urandom_range(20, 80) : $urandom_range(1, 4);
        end else if (pick < 96) begin
          out_tready <= 1'b0;
          len = $urandom_range(1, 3);
        end else begin
          out_tready <= 1'b0;
          len = $urandom_range(8, 30);
        end
        repeat (len) @(posedge clk);
      end
    end
  end

  initial begin : watchdog
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("console_cpu_bus_with_oam_dma_core_tb: done, errors");
    $finish;
  end

  initial begin : stimulus
    int unsigned kind;
    foreach (ram_known[i]) ram_known[i] = 1'b0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // ram, its mirrors and the top of the mirrored window
    put_access(OP_WRITE, 16'h0000, 8'hA5, 1'b0, 1'b0, 1'b0);
    put_access(OP_WRITE, RAM_TOP,  8'h00, 1'b0, 1'b0, 1'b1);
    put_access(OP_READ,  16'h0800, 8'hFF, 1'b0, 1'b0, 1'b0);
    put_access(OP_READ,  16'h07FF, 8'h00, 1'b0, 1'b0, 1'b1);
    // cartridge claim wins over every window
    put_access(OP_READ,  16'hFFFF, 8'h00, 1'b0, 1'b1, 1'b0);
    put_access(OP_WRITE, 16'h0000, 8'h3C, 1'b0, 1'b1, 1'b1);
    // ppu registers at both ends, with and without peek
    put_access(OP_READ,  16'h2000, 8'h00, 1'b1, 1'b0, 1'b0);
    put_access(OP_READ,  PPU_TOP,  8'h00, 1'b0, 1'b0, 1'b1);
    put_access(OP_WRITE, 16'h2007, 8'h81, 1'b1, 1'b0, 1'b0);
    // apu status read, unrouted reads and writes, apu writes
    put_access(OP_READ,  APU_STATUS,   8'h00, 1'b0, 1'b0, 1'b1);
    put_access(OP_READ,  OAM_DMA_REG,  8'h00, 1'b0, 1'b0, 1'b0);
    put_access(OP_READ,  16'h4000,     8'h00, 1'b0, 1'b0, 1'b1);
    put_access(OP_WRITE, 16'h4000,     8'h7E, 1'b0, 1'b0, 1'b0);
    put_access(OP_WRITE, PAD_PORT_TWO, 8'h40, 1'b0, 1'b0, 1'b1);
    put_access(OP_WRITE, 16'hFFFF,     8'h11, 1'b0, 1'b0, 1'b0);
    // pad latch, then serial reads with peek set on one of them
    put_access(OP_WRITE, PAD_PORT_ONE, 8'h01, 1'b0, 1'b0, 1'b1);
    put_access(OP_READ,  PAD_PORT_ONE, 8'h00, 1'b1, 1'b0, 1'b0);
    put_access(OP_READ,  PAD_PORT_TWO, 8'h00, 1'b0, 1'b0, 1'b1);
    // undefined opcode and a tick with no transfer running
    put_access(OP_UNDEFINED, PAD_PORT_ONE, 8'hFF, 1'b1, 1'b0, 1'b0);
    put_access(OP_DMA,       16'h0000,     8'h00, 1'b0, 1'b0, 1'b1);
    // transfer from page 0: even wait tick, alignment tick, read, oam write;
    // the read tick carries peek, which must not reach the bus
    put_access(OP_WRITE, OAM_DMA_REG, 8'h00, 1'b0, 1'b0, 1'b0);
    put_access(OP_DMA,   16'h0000,    8'h00, 1'b0, 1'b0, 1'b0);
    put_access(OP_DMA,   16'h0000,    8'h00, 1'b0, 1'b0, 1'b1);
    put_access(OP_DMA,   16'h0000,    8'h00, 1'b1, 1'b0, 1'b0);
    put_access(OP_DMA,   16'h0000,    8'h00, 1'b0, 1'b0, 1'b1);
    // restart mid-transfer: no new alignment wait
    put_access(OP_WRITE, OAM_DMA_REG, 8'h40, 1'b0, 1'b0, 1'b1);
    put_access(OP_DMA,   16'h0000,    8'h00, 1'b0, 1'b0, 1'b0);
    put_access(OP_DMA,   16'h0000,    8'h00, 1'b0, 1'b0, 1'b1);

    // sender pause until the block has returned everything
    drain();

    // one whole page first, the long sink hold lands inside it
    sprite_dma(pick_page(), 1'b1);
    while (items_done < ITEM_GOAL) begin
      kind = $urandom_range(0, 99);
      if (kind < 38)
        mixed_accesses($urandom_range(5, 40));
      else if (kind < 52)
        pad_readout();
      else if (kind < 74)
        sprite_dma(pick_page(), $urandom_range(0, 99) < 6);
      else if (kind < 86)
        ram_block();
      else if (kind < 98)
        noise($urandom_range(4, 20));
      else
        drain();
    end

    drain();
    // leave room for any stray result
    repeat (8) @(posedge clk);
    if (fault_count == 0 && outstanding == 0)
      $display("console_cpu_bus_with_oam_dma_core_tb: done, clean");
    else
      $display("console_cpu_bus_with_oam_dma_core_tb: done, errors");
    $finish;
  end

endmodule

### filelist.f
design/cbod_pkg.sv
design/cbod_ram.sv
design/console_cpu_bus_with_oam_dma_core.sv
design/cbod_checker.sv
sim/cbod_bus_checker.sv
sim/console_cpu_bus_with_oam_dma_core_tb.sv
